// File: sv/lpr_pkg.sv
// Shared types and constants of the line point rasterizer.
`default_nettype none

package lpr_pkg;

  localparam int COORD_BITS = 12;
  // Rounding remainder: below 2*dx before a column step, plus 2*dy after it.
  localparam int REM_BITS   = COORD_BITS + 2;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [REM_BITS-1:0]   rem_t;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_code_t;

  // Classified command word passed from the front end to the back end.
  typedef struct packed {
    logic   load;
    coord_t left_x;
    coord_t left_y;
    coord_t right_x;
    coord_t right_y;
    logic   falling;
    logic   vertical;
    coord_t dx;
    coord_t dy;
  } op_t;

  // Pixel word waiting in the result queue.
  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pix_t;

endpackage

`default_nettype wire

// File: sv/lpr_front.sv
// Front end: accept commands, order endpoints, and queue classified words.
`default_nettype none

module lpr_front (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push,
  output logic                         full,
  input  wire logic                    command,
  input  wire lpr_pkg::coord_t         start_x,
  input  wire lpr_pkg::coord_t         start_y,
  input  wire lpr_pkg::coord_t         end_x,
  input  wire lpr_pkg::coord_t         end_y,
  output logic                         op_valid,
  output lpr_pkg::op_t                 op,
  input  wire logic                    op_take
);

  lpr_pkg::op_t    classified;
  lpr_pkg::op_t    slots [2];
  logic [1:0]      count;
  logic [1:0]      count_next;
  logic            wr_ptr;
  logic            rd_ptr;
  logic            push_ok;
  logic            pop_ok;
  logic            swap;

  // Order endpoints; equal x takes the second endpoint as the left one.
  always_comb begin
    swap = !(start_x < end_x);
    classified.load     = (command == lpr_pkg::CMD_LOAD);
    classified.left_x   = swap ? end_x   : start_x;
    classified.left_y   = swap ? end_y   : start_y;
    classified.right_x  = swap ? start_x : end_x;
    classified.right_y  = swap ? start_y : end_y;
    classified.falling  = !(classified.left_y < classified.right_y);
    classified.vertical = (classified.left_x == classified.right_x);
    classified.dx       = classified.right_x - classified.left_x;
    classified.dy       = classified.falling ? (classified.left_y - classified.right_y)
                                             : (classified.right_y - classified.left_y);
  end

  assign full     = (count == 2'd2);
  assign op_valid = (count != 2'd0);
  assign op       = slots[rd_ptr];
  assign push_ok  = push && !full;
  assign pop_ok   = op_take && op_valid;

  always_comb begin
    count_next = count;
    if (push_ok && !pop_ok) begin
      count_next = count + 2'd1;
    end else if (!push_ok && pop_ok) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count_next;
      if (push_ok) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop_ok) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wr_ptr] <= classified;
    end
  end

endmodule

`default_nettype wire

// File: sv/lpr_back.sv
// Back end: walk the loaded line one pixel per advance and queue the pixels.
`default_nettype none

module lpr_back (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    op_valid,
  input  wire lpr_pkg::op_t            op,
  output logic                         op_take,
  output logic                         empty,
  input  wire logic                    pop,
  output lpr_pkg::pix_t                head
);

  // Line state.
  lpr_pkg::coord_t right_x;
  lpr_pkg::coord_t right_y;
  logic            falling;
  logic            vertical;
  lpr_pkg::coord_t column;
  lpr_pkg::coord_t row;
  lpr_pkg::coord_t dx;
  lpr_pkg::coord_t dy;
  lpr_pkg::rem_t   rem;
  logic            filling;
  logic            active;

  lpr_pkg::coord_t column_next;
  lpr_pkg::coord_t row_next;
  lpr_pkg::rem_t   rem_next;
  logic            filling_next;
  logic            active_next;

  lpr_pkg::rem_t   dx2;
  lpr_pkg::rem_t   dx4;
  lpr_pkg::rem_t   dy2;
  lpr_pkg::rem_t   rem_sum;
  lpr_pkg::coord_t row_step;

  // Result queue.
  lpr_pkg::pix_t   slots [2];
  lpr_pkg::pix_t   pix;
  logic [1:0]      count;
  logic [1:0]      count_next;
  logic            wr_ptr;
  logic            rd_ptr;
  logic            emit;
  logic            pop_ok;

  assign dx2      = {1'b0, dx, 1'b0};
  assign dx4      = {dx, 2'b00};
  assign dy2      = {1'b0, dy, 1'b0};
  assign rem_sum  = rem + dy2;
  assign row_step = falling ? (row - lpr_pkg::coord_t'(1)) : (row + lpr_pkg::coord_t'(1));

  // Take a word only when a pixel it may produce has room.
  assign op_take = op_valid && (count != 2'd2);
  assign emit    = op_take && !op.load && active;

  always_comb begin
    column_next  = column;
    row_next     = row;
    rem_next     = rem;
    filling_next = filling;
    active_next  = active;
    pix.x        = column;
    pix.y        = row;
    pix.last     = 1'b0;
    if (vertical) begin
      if (row == right_y) begin
        pix.last    = 1'b1;
        active_next = 1'b0;
      end else begin
        row_next = row_step;
      end
    end else if (filling) begin
      // Remainder below 4*dx: this row is the last one of the gap.
      row_next = row_step;
      rem_next = rem - dx2;
      if (rem < dx4) begin
        filling_next = 1'b0;
        column_next  = column + lpr_pkg::coord_t'(1);
      end
    end else if (column == right_x) begin
      pix.last    = 1'b1;
      active_next = 1'b0;
    end else if (rem_sum >= dx4) begin
      // Next column's row is two or more away: fill the gap first.
      filling_next = 1'b1;
      row_next     = row_step;
      rem_next     = rem_sum - dx2;
    end else if (rem_sum >= dx2) begin
      column_next = column + lpr_pkg::coord_t'(1);
      row_next    = row_step;
      rem_next    = rem_sum - dx2;
    end else begin
      column_next = column + lpr_pkg::coord_t'(1);
      rem_next    = rem_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      filling <= 1'b0;
    end else if (op_take) begin
      if (op.load) begin
        active  <= 1'b1;
        filling <= 1'b0;
      end else if (active) begin
        active  <= active_next;
        filling <= filling_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_take) begin
      if (op.load) begin
        right_x  <= op.right_x;
        right_y  <= op.right_y;
        falling  <= op.falling;
        vertical <= op.vertical;
        column   <= op.left_x;
        row      <= op.left_y;
        dx       <= op.dx;
        dy       <= op.dy;
        rem      <= {2'b00, op.dx} - {{(lpr_pkg::REM_BITS-1){1'b0}}, op.falling};
      end else if (active) begin
        column <= column_next;
        row    <= row_next;
        rem    <= rem_next;
      end
    end
  end

  // Two-entry result queue.
  assign empty  = (count == 2'd0);
  assign head   = slots[rd_ptr];
  assign pop_ok = pop && !empty;

  always_comb begin
    count_next = count;
    if (emit && !pop_ok) begin
      count_next = count + 2'd1;
    end else if (!emit && pop_ok) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count_next;
      if (emit) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop_ok) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      slots[wr_ptr] <= pix;
    end
  end

endmodule

`default_nettype wire

// File: sv/line_point_rasterizer.sv
// Top level of the line point rasterizer: front end, command queue, back end.
//
//  channel   words carried                               handshake
//  -------   ------------------------------------------  -----------------------
//  command   command, start_x, start_y, end_x, end_y      push / full
//  pixel     pixel_x, pixel_y, last_pixel                 pop / empty
//
// One command word is taken per cycle while full is low. The front end orders
// the endpoints, works out dx, dy and the slope direction and drops the word
// into a two-entry queue. The back end takes one word per cycle while the
// pixel queue has room, so an advance yields one pixel per cycle; the rounding
// remainder update (adds and compares against 2*dx and 4*dx) is combinational.
// Reset (rst, synchronous) empties both queues and drops any loaded line.
// A stalled pixel queue holds the back end; the command queue then fills and
// raises full once it holds two words.
`default_nettype none

module line_point_rasterizer (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push,
  output logic                         full,
  input  wire logic                    command,
  input  wire lpr_pkg::coord_t         start_x,
  input  wire lpr_pkg::coord_t         start_y,
  input  wire lpr_pkg::coord_t         end_x,
  input  wire lpr_pkg::coord_t         end_y,
  output logic                         empty,
  input  wire logic                    pop,
  output lpr_pkg::coord_t              pixel_x,
  output lpr_pkg::coord_t              pixel_y,
  output logic                         last_pixel
);

  logic          op_valid;
  logic          op_take;
  lpr_pkg::op_t  op;
  lpr_pkg::pix_t head;

  lpr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .command  (command),
    .start_x  (start_x),
    .start_y  (start_y),
    .end_x    (end_x),
    .end_y    (end_y),
    .op_valid (op_valid),
    .op       (op),
    .op_take  (op_take)
  );

  lpr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op       (op),
    .op_take  (op_take),
    .empty    (empty),
    .pop      (pop),
    .head     (head)
  );

  // Drive the oldest waiting pixel onto the result ports.
  assign pixel_x    = head.x;
  assign pixel_y    = head.y;
  assign last_pixel = head.last;

endmodule

`default_nettype wire
